>>> src/mpib_pkg.sv
// Shared constants, types and structures of the Metropolis particle-in-box step unit.
`default_nettype none
package mpib_pkg;

  localparam int NumParticles = 1024;
  localparam int LevelBits    = 8;
  localparam int SlotCount    = NumParticles * 3;
  localparam int AddrW        = $clog2(SlotCount);
  localparam int TempW        = 16;
  localparam int NeglogW      = 16;
  localparam int ProdW        = TempW + NeglogW;
  localparam int FracBits     = 20;
  localparam int HiW          = (LevelBits + 1 > ProdW - FracBits) ?
                                LevelBits + 1 : ProdW - FracBits;
  localparam int EnergyW      = 32;
  localparam int OutLevelW    = 8;
  localparam int InDataW      = 32;
  localparam int OutDataW     = 48;

  localparam logic [TempW-1:0]   TempReset   = 16'd519;
  localparam logic [EnergyW-1:0] EnergyReset = EnergyW'(3 * NumParticles);

  typedef logic [LevelBits-1:0] level_t;
  typedef logic [AddrW-1:0]     addr_t;

  localparam level_t LevelOne = level_t'(1);

  typedef struct packed {
    logic   en;
    addr_t  addr;
    level_t data;
  } mem_wr_t;

  typedef struct packed {
    addr_t            addr;
    logic             go_up;
    logic             in_range;
    logic [ProdW-1:0] product;
  } step_t;

  typedef struct packed {
    logic [OutLevelW-1:0] new_level;
    logic                 accepted;
    logic [EnergyW-1:0]   energy;
  } result_t;

endpackage
`default_nettype wire

>>> src/metropolis_particle_in_box_step_unit.sv
// Top level of the Metropolis particle-in-box step unit: handshakes, stages and wiring.
//
// Each input transfer proposes one level change for one particle and axis, and gives exactly one
// result transfer when the output is free. The unit sustains one step per clock unless the output
// stalls: the level store is read in the cycle of the input transfer and written back as the step
// leaves the decision stage, and a last-write register forwards the fresh level when consecutive
// steps hit the same slot. The output register and the decision stage form two slots, so an input
// is still taken while a finished result waits. After reset the level store is cleared to one by a
// pass, one slot per cycle, during which s_axis_tready stays low; the temperature register can be
// written at any time the unit is idle and cfg_ready_o is always high.
`default_nettype none
module metropolis_particle_in_box_step_unit (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [mpib_pkg::TempW-1:0]     cfg_data_i,     // temperature_scaled
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  // particle [9:0], axis [11:10], go_up [12], neglog_u [28:13], zero [31:29]
  input  logic [mpib_pkg::InDataW-1:0]   s_axis_tdata,
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // energy_units [31:0], accepted [32], new_level [40:33], zero [47:41]
  output logic [mpib_pkg::OutDataW-1:0]  m_axis_tdata
);
  import mpib_pkg::*;

  logic [TempW-1:0]    temp_q;
  logic [9:0]          in_particle;
  logic [1:0]          in_axis;
  logic                in_go_up;
  logic [NeglogW-1:0]  in_neglog;
  logic [11:0]         slot_wide;
  logic                busy, in_fire, s1_adv, s1_fire;
  logic                s1_valid_q, out_valid_q;
  step_t               s1_q, s1_d;
  result_t             result, out_q;
  mem_wr_t             wr;
  level_t              rd_data;

  assign in_particle = s_axis_tdata[9:0];
  assign in_axis     = s_axis_tdata[11:10];
  assign in_go_up    = s_axis_tdata[12];
  assign in_neglog   = s_axis_tdata[28:13];

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      temp_q <= TempReset;
    end else if (cfg_valid_i) begin
      temp_q <= cfg_data_i;
    end
  end

  assign slot_wide = ({2'b00, in_particle} << 1) + {2'b00, in_particle} + {10'b0, in_axis};

  assign s1_d.addr     = addr_t'(slot_wide);
  assign s1_d.go_up    = in_go_up;
  assign s1_d.in_range = ({22'b0, in_particle} < 32'(NumParticles)) && (in_axis != 2'd3);
  assign s1_d.product  = in_neglog * temp_q;

  assign s1_adv        = !out_valid_q || m_axis_tready;
  assign s1_fire       = s1_valid_q && s1_adv;
  assign s_axis_tready = !busy && (!s1_valid_q || s1_adv);
  assign in_fire       = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_fire) begin
        s1_valid_q <= 1'b1;
      end else if (s1_fire) begin
        s1_valid_q <= 1'b0;
      end
      if (s1_fire) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_q <= s1_d;
    end
    if (s1_fire) begin
      out_q <= result;
    end
  end

  mpib_level_mem u_level_mem (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_en_i   (in_fire),
    .rd_addr_i (s1_d.addr),
    .wr_i      (wr),
    .rd_data_o (rd_data),
    .busy_o    (busy)
  );

  mpib_update u_update (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .fire_i    (s1_fire),
    .step_i    (s1_q),
    .rd_data_i (rd_data),
    .wr_o      (wr),
    .result_o  (result)
  );

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {{(OutDataW - $bits(result_t)){1'b0}}, out_q};

endmodule
`default_nettype wire

>>> src/mpib_level_mem.sv
// Level store: synchronous memory with a registered read and a clearing pass after reset.
`default_nettype none
module mpib_level_mem (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             rd_en_i,
  input  mpib_pkg::addr_t  rd_addr_i,
  input  mpib_pkg::mem_wr_t wr_i,
  output mpib_pkg::level_t rd_data_o,
  output logic             busy_o
);
  import mpib_pkg::*;

  level_t mem_q [SlotCount];
  level_t rd_data_q;
  addr_t  clr_cnt_q, clr_cnt_d;
  logic   clr_q, clr_d;

  always_comb begin
    clr_d     = clr_q;
    clr_cnt_d = clr_cnt_q;
    if (clr_q) begin
      if (clr_cnt_q == addr_t'(SlotCount - 1)) begin
        clr_d = 1'b0;
      end else begin
        clr_cnt_d = clr_cnt_q + addr_t'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q     <= 1'b1;
      clr_cnt_q <= '0;
    end else begin
      clr_q     <= clr_d;
      clr_cnt_q <= clr_cnt_d;
    end
  end

  // Every level starts at one; the pass walks the store once before items are taken.
  always_ff @(posedge clk_i) begin
    if (clr_q) begin
      mem_q[clr_cnt_q] <= LevelOne;
    end else if (wr_i.en) begin
      mem_q[wr_i.addr] <= wr_i.data;
    end
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;
  assign busy_o    = clr_q;

endmodule
`default_nettype wire

>>> src/mpib_update.sv
// Acceptance decision, level write-back with forwarding, and the running energy total.
`default_nettype none
module mpib_update (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              fire_i,
  input  mpib_pkg::step_t   step_i,
  input  mpib_pkg::level_t  rd_data_i,
  output mpib_pkg::mem_wr_t wr_o,
  output mpib_pkg::result_t result_o
);
  import mpib_pkg::*;

  logic                 fwd_valid_q;
  addr_t                fwd_addr_q;
  level_t               fwd_data_q;
  logic [EnergyW-1:0]   energy_q, energy_d;
  level_t               level, level_new;
  logic [LevelBits:0]   delta_up, delta_dn;
  logic [HiW-1:0]       prod_hi, delta_cmp;
  logic                 prod_lo_nz, up_ok, dn_ok, accept;

  // The read for this item may be issued while the previous item is still being written.
  assign level = (fwd_valid_q && fwd_addr_q == step_i.addr) ? fwd_data_q : rd_data_i;

  assign delta_up   = {level, 1'b1};
  assign delta_dn   = {level, 1'b0} - {{LevelBits{1'b0}}, 1'b1};
  assign prod_hi    = HiW'(step_i.product[ProdW-1:FracBits]);
  assign delta_cmp  = HiW'(delta_up);
  assign prod_lo_nz = |step_i.product[FracBits-1:0];

  // The product is strictly above delta scaled by two to the twentieth.
  assign up_ok  = (level != '1) &&
                  ((prod_hi > delta_cmp) || ((prod_hi == delta_cmp) && prod_lo_nz));
  assign dn_ok  = level > LevelOne;
  assign accept = step_i.in_range && (step_i.go_up ? up_ok : dn_ok);

  always_comb begin
    level_new = level;
    energy_d  = energy_q;
    if (accept) begin
      if (step_i.go_up) begin
        level_new = level + LevelOne;
        energy_d  = energy_q + EnergyW'(delta_up);
      end else begin
        level_new = level - LevelOne;
        energy_d  = energy_q - EnergyW'(delta_dn);
      end
    end
  end

  assign wr_o.en   = fire_i && step_i.in_range;
  assign wr_o.addr = step_i.addr;
  assign wr_o.data = level_new;

  assign result_o.energy    = energy_d;
  assign result_o.accepted  = accept;
  assign result_o.new_level = step_i.in_range ? OutLevelW'(level_new) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      energy_q    <= EnergyReset;
      fwd_valid_q <= 1'b0;
    end else if (fire_i) begin
      energy_q <= energy_d;
      if (wr_o.en) begin
        fwd_valid_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_o.en) begin
      fwd_addr_q <= step_i.addr;
      fwd_data_q <= level_new;
    end
  end

endmodule
`default_nettype wire

>>> src/mpib_checker.sv
// Port-level checks of the step unit and the bind that attaches them.
`default_nettype none
module mpib_checker (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           s_axis_tready,
  input logic                           m_axis_tvalid,
  input logic                           m_axis_tready,
  input logic [mpib_pkg::OutDataW-1:0]  m_axis_tdata
);

  // A result waiting for the sink keeps its value.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled result changed");

  // Once reset has been seen at a clock edge, no result is offered at the next one.
  assert property (@(posedge clk_i) !rst_ni |=> !m_axis_tvalid)
    else $error("result offered during reset");

  // The clearing pass keeps the input closed right after reset is released.
  assert property (@(posedge clk_i) $rose(rst_ni) |-> !s_axis_tready)
    else $error("input open before the level store is cleared");

  // An applied move never leaves a level of zero.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[32] |-> m_axis_tdata[40:33] != 8'd0)
    else $error("accepted move reports level zero");

endmodule

bind metropolis_particle_in_box_step_unit mpib_checker u_mpib_checker (.*);
`default_nettype wire

>>> bench/tb.sv
// Self-checking testbench for the Metropolis particle-in-box step unit.
`timescale 1ns / 1ps

module tb;
  import mpib_pkg::*;

  typedef enum logic [1:0] {AXIS_X, AXIS_Y, AXIS_Z, AXIS_NONE} axis_e;

  localparam logic   MOVE_UP   = 1'b1;
  localparam logic   MOVE_DOWN = 1'b0;
  localparam level_t TopLevel  = '1;

  typedef struct {
    logic [9:0]         particle;
    axis_e              axis;
    logic               go_up;
    logic [NeglogW-1:0] neglog;
  } proposal_t;

  // Holds a copy of the level store, the total energy and the temperature, and keeps the
  // results that the unit still owes, oldest first.
  class energy_scoreboard;
    level_t             levels [SlotCount];
    logic [EnergyW-1:0] energy;
    logic [TempW-1:0]   temp;
    result_t            owed_q [$];
    int                 errors;
    int                 steps;
    int                 checked;
    int                 applied;
    int                 top_blocked;

    function new();
      foreach (levels[k]) levels[k] = LevelOne;
      energy = EnergyReset;
      temp   = TempReset;
    endfunction

    function int pending();
      return owed_q.size();
    endfunction

    function void set_temp(logic [TempW-1:0] value);
      temp = value;
    endfunction

    function void note_step(proposal_t p);
      result_t     r;
      int unsigned slot;
      level_t      n;
      logic [63:0] product;
      logic [63:0] threshold;
      r = '0;
      if (p.particle < NumParticles && p.axis != AXIS_NONE) begin
        slot = p.particle * 3 + int'(p.axis);
        n = levels[slot];
        if (p.go_up == MOVE_UP) begin
          product   = 64'(p.neglog) * 64'(temp);
          threshold = (64'(n) * 2 + 1) << FracBits;
          if (n == TopLevel) begin
            top_blocked++;
          end else if (product > threshold) begin
            energy     = energy + 32'(n) * 2 + 1;
            n          = n + 1'b1;
            r.accepted = 1'b1;
          end
        end else if (n > LevelOne) begin
          energy     = energy - (32'(n) * 2 - 1);
          n          = n - 1'b1;
          r.accepted = 1'b1;
        end
        levels[slot] = n;
        r.new_level  = OutLevelW'(n);
      end
      r.energy = energy;
      if (r.accepted) applied++;
      steps++;
      owed_q = {owed_q, r};
    endfunction

    task report_mismatch(string field, logic [63:0] got, logic [63:0] want);
      $display("[%0t] %s: got 0x%0h, expected 0x%0h", $time, field, got, want);
      errors++;
    endtask

    task check_result(logic [OutDataW-1:0] tdata);
      result_t got;
      result_t want;
      if (owed_q.size() == 0) begin
        report_mismatch("result transfer with no step outstanding", 64'(tdata), 64'd0);
        return;
      end
      want = owed_q.pop_front();
      got  = result_t'(tdata[$bits(result_t)-1:0]);
      if (got.energy !== want.energy)
        report_mismatch("energy_units", 64'(got.energy), 64'(want.energy));
      if (got.accepted !== want.accepted)
        report_mismatch("accepted", 64'(got.accepted), 64'(want.accepted));
      if (got.new_level !== want.new_level)
        report_mismatch("new_level", 64'(got.new_level), 64'(want.new_level));
      if (tdata[OutDataW-1:$bits(result_t)] !== '0)
        report_mismatch("padding", 64'(tdata[OutDataW-1:$bits(result_t)]), 64'd0);
      checked++;
    endtask
  endclass

  logic                clk_i         = 1'b0;
  logic                rst_ni        = 1'b0;
  logic                cfg_valid_i   = 1'b0;
  logic                cfg_ready_o;
  logic [TempW-1:0]    cfg_data_i    = '0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [InDataW-1:0]  s_axis_tdata  = '0;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [OutDataW-1:0] m_axis_tdata;

  energy_scoreboard sb = new();
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_cycles   = 0;
  int temp_writes   = 0;
  int hot_particles [8] = '{0, 1, 5, 7, 64, 300, 512, 1023};

  metropolis_particle_in_box_step_unit dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Receiver: a requested hold-off keeps tready low for a counted stretch, otherwise it
  // idles at the current rate.
  always @(negedge clk_i) begin
    if (hold_cycles > 0) begin
      m_axis_tready <= 1'b0;
      hold_cycles = hold_cycles - 1;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tdata);
  end

  // Called just after a falling edge; returns just after the falling edge that follows the
  // transfer.
  task automatic send_step(proposal_t p);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= InDataW'({p.neglog, p.go_up, p.axis, p.particle});
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_step(p);
    @(negedge clk_i);
  endtask

  task automatic propose(int particle, axis_e axis, logic go_up, int neglog);
    proposal_t p;
    p.particle = 10'(particle);
    p.axis     = axis;
    p.go_up    = go_up;
    p.neglog   = NeglogW'(neglog);
    send_step(p);
  endtask

  // Most proposals hit a few hot particles so that levels climb and fall far; the rest spread
  // over the whole range, with an occasional invalid axis.
  task automatic propose_random(int up_pct);
    proposal_t p;
    p.particle = ($urandom_range(99) < 70) ? 10'(hot_particles[$urandom_range(7)])
                                            : 10'($urandom_range(NumParticles - 1));
    p.axis     = ($urandom_range(99) < 6) ? AXIS_NONE : axis_e'($urandom_range(2));
    p.go_up    = ($urandom_range(99) < up_pct) ? MOVE_UP : MOVE_DOWN;
    p.neglog   = ($urandom_range(3) == 0) ? NeglogW'($urandom_range(4095))
                                          : NeglogW'($urandom_range(65535));
    send_step(p);
  endtask

  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    while (sb.pending() != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic write_temp(logic [TempW-1:0] value);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    sb.set_temp(value);
    temp_writes++;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
    @(negedge clk_i);
  endtask

  initial begin
    repeat (8) @(negedge clk_i);
    rst_ni <= 1'b1;
    send_idle_pct = 35;
    recv_idle_pct = 64;

    // Reset temperature: floor, a simple climb, an invalid axis, and back-to-back steps on
    // one slot and on neighbouring slots so that forwarding is exercised.
    propose(0, AXIS_X, MOVE_DOWN, 0);
    propose(0, AXIS_X, MOVE_UP, 16'hFFFF);
    propose(0, AXIS_X, MOVE_UP, 0);
    propose(0, AXIS_X, MOVE_DOWN, 16'h1234);
    propose(0, AXIS_NONE, MOVE_UP, 16'hFFFF);
    propose(1023, AXIS_NONE, MOVE_DOWN, 0);
    propose(1023, AXIS_Z, MOVE_UP, 16'hFFFF);
    propose(1023, AXIS_Z, MOVE_UP, 16'hFFFF);
    propose(1023, AXIS_Z, MOVE_UP, 16'hFFFF);
    propose(1022, AXIS_Z, MOVE_UP, 16'h8000);
    propose(1023, AXIS_Z, MOVE_DOWN, 0);
    propose(512, AXIS_Y, MOVE_UP, 16'h7FFF);
    propose(512, AXIS_Y, MOVE_DOWN, 16'hFFFF);
    wait_idle();

    // A product exactly equal to the energy step is rejected; one more is accepted.
    write_temp(16'd768);
    propose(5, AXIS_Y, MOVE_UP, 4096);
    propose(5, AXIS_Y, MOVE_UP, 4097);
    wait_idle();

    // With zero temperature no up move passes, but down moves still do.
    write_temp(16'd0);
    propose(1023, AXIS_Z, MOVE_UP, 16'hFFFF);
    propose(5, AXIS_Y, MOVE_UP, 16'hFFFF);
    propose(5, AXIS_Y, MOVE_DOWN, 0);
    wait_idle();

    // Hottest setting: one slot is driven to the top level and held there, while the output
    // is stalled for a long stretch at first so that the unit backs up.
    write_temp(16'hFFFF);
    hold_cycles = 300;
    repeat (TopLevel + 5) propose(7, AXIS_Y, MOVE_UP, 16'hFFFF);
    propose(7, AXIS_Y, MOVE_DOWN, 0);
    propose(7, AXIS_Y, MOVE_UP, 16'hFFFF);
    repeat (175) propose_random(75);
    wait_idle();

    send_idle_pct = 64;
    recv_idle_pct = 35;
    write_temp(16'd1);
    repeat (175) propose_random(40);
    wait_idle();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    write_temp(TempW'($urandom_range(256, 8192)));
    repeat (170) propose_random(55);
    wait_idle();
    repeat (8) @(negedge clk_i);

    $display("Ran %0d proposals under %0d temperature settings: %0d moves applied, %0d %s",
             sb.steps, temp_writes, sb.applied, sb.top_blocked, "blocked at the top level.");
    $display("Checked %0d results with idling on either side, a long output stall %s",
             sb.checked, "and gapless runs.");
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("metropolis_particle_in_box_step_unit test passed");
    end else begin
      $display("metropolis_particle_in_box_step_unit test failed");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("metropolis_particle_in_box_step_unit test failed");
    $finish;
  end

endmodule

>>> metropolis_particle_in_box_step_unit.f
src/mpib_pkg.sv
src/mpib_level_mem.sv
src/mpib_update.sv
src/metropolis_particle_in_box_step_unit.sv
src/mpib_checker.sv
bench/tb.sv
